### hdl/dtbl_pkg.sv
`default_nettype none

package dtbl_pkg;

  // Field and register widths
  localparam int unsigned TIME_BITS       = 48;
  localparam int unsigned BYTES_BITS      = 32;
  localparam int unsigned REQ_RATE_BITS   = 20;
  localparam int unsigned BYTE_RATE_BITS  = 31;
  localparam int unsigned REQ_LEVEL_BITS  = 30;
  localparam int unsigned BYTE_LEVEL_BITS = 41;
  localparam int unsigned NEED_BITS       = 42;
  localparam int unsigned DT_BITS         = 10;
  localparam int unsigned CFG_INDEX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS   = 31;

  // Milli-tokens per token, and the elapsed-time clamp in ms
  localparam logic [DT_BITS-1:0] TOKEN_SCALE = 10'd1000;
  localparam logic [DT_BITS-1:0] DT_LIMIT    = 10'd1000;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_REQUEST_RATE = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BYTE_RATE    = 1'd1;

  typedef enum logic [1:0] {
    OUTCOME_GRANT   = 2'd0,
    OUTCOME_WAIT    = 2'd1,
    OUTCOME_ABANDON = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]  now_ms;
    logic [BYTES_BITS-1:0] request_bytes;
    logic                  abort;
  } in_word_t;

  typedef struct packed {
    outcome_t                   outcome;
    logic [REQ_LEVEL_BITS-1:0]  request_level;
    logic [BYTE_LEVEL_BITS-1:0] byte_level;
  } out_word_t;

  typedef struct packed {
    logic [REQ_RATE_BITS-1:0]   request_rate;
    logic [BYTE_RATE_BITS-1:0]  byte_rate;
    logic [REQ_LEVEL_BITS-1:0]  req_cap;
    logic [BYTE_LEVEL_BITS-1:0] byte_cap;
  } cfg_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]       last_refill_ms;
    logic [REQ_LEVEL_BITS-1:0]  request_tokens;
    logic [BYTE_LEVEL_BITS-1:0] byte_tokens;
  } bucket_state_t;

endpackage

`default_nettype wire

### hdl/dtbl_eval.sv
`default_nettype none

module dtbl_eval (
  input  var dtbl_pkg::cfg_t                    cfg,
  input  var dtbl_pkg::bucket_state_t           state,
  input  var dtbl_pkg::in_word_t                word,
  input  var logic [dtbl_pkg::NEED_BITS-1:0]    byte_cost,
  output dtbl_pkg::bucket_state_t               state_next,
  output dtbl_pkg::out_word_t                   result
);

  logic                                   req_on;
  logic                                   byte_on;
  logic                                   first;
  logic                                   advanced;
  logic [dtbl_pkg::TIME_BITS-1:0]         elapsed;
  logic [dtbl_pkg::DT_BITS-1:0]           dt;
  logic [dtbl_pkg::REQ_LEVEL_BITS-1:0]    req_gain;
  logic [dtbl_pkg::REQ_LEVEL_BITS:0]      req_sum;
  logic [dtbl_pkg::REQ_LEVEL_BITS-1:0]    req_fill;
  logic [dtbl_pkg::BYTE_LEVEL_BITS-1:0]   byte_gain;
  logic [dtbl_pkg::BYTE_LEVEL_BITS:0]     byte_sum;
  logic [dtbl_pkg::BYTE_LEVEL_BITS-1:0]   byte_fill;
  logic [dtbl_pkg::REQ_LEVEL_BITS-1:0]    req_level;
  logic [dtbl_pkg::BYTE_LEVEL_BITS-1:0]   byte_level;
  logic                                   req_short;
  logic                                   byte_short;
  logic                                   ok;
  dtbl_pkg::bucket_state_t                stepped;

  assign req_on   = cfg.request_rate != '0;
  assign byte_on  = cfg.byte_rate != '0;
  assign first    = state.last_refill_ms == '0;
  assign advanced = word.now_ms > state.last_refill_ms;
  assign elapsed  = word.now_ms - state.last_refill_ms;
  assign dt       = (elapsed > dtbl_pkg::TIME_BITS'(dtbl_pkg::DT_LIMIT))
                    ? dtbl_pkg::DT_LIMIT : elapsed[dtbl_pkg::DT_BITS-1:0];

  // Refill: elapsed ms times rate, capped at one second's worth
  assign req_gain  = dtbl_pkg::REQ_LEVEL_BITS'(dt)
                   * dtbl_pkg::REQ_LEVEL_BITS'(cfg.request_rate);
  assign req_sum   = {1'b0, state.request_tokens} + {1'b0, req_gain};
  assign req_fill  = (req_sum > {1'b0, cfg.req_cap}) ? cfg.req_cap
                                                     : req_sum[dtbl_pkg::REQ_LEVEL_BITS-1:0];
  assign byte_gain = dtbl_pkg::BYTE_LEVEL_BITS'(dt)
                   * dtbl_pkg::BYTE_LEVEL_BITS'(cfg.byte_rate);
  assign byte_sum  = {1'b0, state.byte_tokens} + {1'b0, byte_gain};
  assign byte_fill = (byte_sum > {1'b0, cfg.byte_cap}) ? cfg.byte_cap
                                                       : byte_sum[dtbl_pkg::BYTE_LEVEL_BITS-1:0];

  always_comb begin
    if (first) begin
      req_level  = cfg.req_cap;
      byte_level = cfg.byte_cap;
    end else if (advanced) begin
      req_level  = req_on ? req_fill : state.request_tokens;
      byte_level = byte_on ? byte_fill : state.byte_tokens;
    end else begin
      req_level  = state.request_tokens;
      byte_level = state.byte_tokens;
    end
  end

  assign req_short  = req_on && (req_level < dtbl_pkg::REQ_LEVEL_BITS'(dtbl_pkg::TOKEN_SCALE));
  assign byte_short = byte_on && ({1'b0, byte_level} < byte_cost);
  assign ok         = !req_short && !byte_short;

  always_comb begin
    stepped.last_refill_ms = (first || advanced) ? word.now_ms : state.last_refill_ms;
    stepped.request_tokens = (ok && req_on)
                             ? req_level - dtbl_pkg::REQ_LEVEL_BITS'(dtbl_pkg::TOKEN_SCALE)
                             : req_level;
    stepped.byte_tokens    = (ok && byte_on)
                             ? byte_level - byte_cost[dtbl_pkg::BYTE_LEVEL_BITS-1:0]
                             : byte_level;
  end

  always_comb begin
    if (!req_on && !byte_on) begin
      state_next     = state;
      result.outcome = dtbl_pkg::OUTCOME_GRANT;
    end else if (word.abort) begin
      state_next     = state;
      result.outcome = dtbl_pkg::OUTCOME_ABANDON;
    end else begin
      state_next     = stepped;
      result.outcome = ok ? dtbl_pkg::OUTCOME_GRANT : dtbl_pkg::OUTCOME_WAIT;
    end
    result.request_level = state_next.request_tokens;
    result.byte_level    = state_next.byte_tokens;
  end

endmodule

`default_nettype wire

### hdl/dual_token_bucket_limiter.sv
`default_nettype none

// Dual token bucket admission limiter. Each input word is one admission attempt
// (time in ms, request size in bytes, abort flag); each attempt returns exactly
// one output word: granted, wait-and-retry, or abandoned, plus both bucket levels
// in milli-tokens after the attempt. Throughput is one attempt per clock while the
// output is not stalled. An accepted attempt is loaded into the input register, then
// the refill/check/charge logic feeds the output register; it waits in the input
// register while the output register is full and stalled. The bucket state updates
// at the same edge that loads the output register, so the next attempt always
// sees the result of the previous one. Write request_rate (index 0) and byte_rate
// (index 1) only while no attempt is in flight; a rate of zero disables its bucket
// and both zero passes every attempt through as granted.
module dual_token_bucket_limiter (
  input  var logic                                    clk,
  input  var logic                                    rst,
  input  var logic                                    in_valid,
  output logic                                        in_stall,
  input  var dtbl_pkg::in_word_t                      in_word,
  output logic                                        out_valid,
  input  var logic                                    out_stall,
  output dtbl_pkg::out_word_t                         out_word,
  input  var logic                                    cfg_valid,
  output logic                                        cfg_ready,
  input  var logic [dtbl_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  var logic [dtbl_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  dtbl_pkg::cfg_t                       cfg;
  dtbl_pkg::bucket_state_t              state;
  dtbl_pkg::bucket_state_t              state_next;
  dtbl_pkg::out_word_t                  result;
  logic                                 hold_valid;
  dtbl_pkg::in_word_t                   hold_word;
  logic [dtbl_pkg::NEED_BITS-1:0]       hold_need;
  logic                                 accept;
  logic                                 advance;

  // Configuration is always taken; the caps are precomputed here so the
  // per-attempt path carries only the refill multiply.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dtbl_pkg::REG_REQUEST_RATE: begin
          cfg.request_rate <= cfg_data[dtbl_pkg::REQ_RATE_BITS-1:0];
          cfg.req_cap      <= dtbl_pkg::REQ_LEVEL_BITS'(cfg_data[dtbl_pkg::REQ_RATE_BITS-1:0])
                            * dtbl_pkg::REQ_LEVEL_BITS'(dtbl_pkg::TOKEN_SCALE);
        end
        dtbl_pkg::REG_BYTE_RATE: begin
          cfg.byte_rate <= cfg_data[dtbl_pkg::BYTE_RATE_BITS-1:0];
          cfg.byte_cap  <= dtbl_pkg::BYTE_LEVEL_BITS'(cfg_data[dtbl_pkg::BYTE_RATE_BITS-1:0])
                         * dtbl_pkg::BYTE_LEVEL_BITS'(dtbl_pkg::TOKEN_SCALE);
        end
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  // Advance the held attempt whenever the output register is free or draining;
  // stall the input only when both registers are full and the output is stalled.
  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Input register: hold the word and its byte need (bytes times 1000)
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_word <= in_word;
      hold_need <= dtbl_pkg::NEED_BITS'(in_word.request_bytes)
                 * dtbl_pkg::NEED_BITS'(dtbl_pkg::TOKEN_SCALE);
    end
  end

  // Refill, check and charge both buckets
  dtbl_eval u_eval (
    .cfg        (cfg),
    .state      (state),
    .word       (hold_word),
    .byte_cost  (hold_need),
    .state_next (state_next),
    .result     (result)
  );

  // Bucket state commits together with the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result;
    end
  end

`ifndef SYNTHESIS
  // An aborted attempt with a bucket enabled must leave the state untouched
  assert property (@(posedge clk) disable iff (rst)
    advance && hold_word.abort && (cfg.request_rate != '0 || cfg.byte_rate != '0)
    |=> $stable(state))
    else $error("abort changed bucket state");

  // The reported levels are the state left behind by the attempt
  assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid && out_word.request_level == state.request_tokens
                && out_word.byte_level == state.byte_tokens)
    else $error("output levels differ from committed state");

  // A held attempt that cannot advance stays in the input register
  assert property (@(posedge clk) disable iff (rst)
    hold_valid && !advance |=> hold_valid && $stable(hold_word) && $stable(hold_need))
    else $error("held attempt lost while output stalled");
`endif

endmodule

`default_nettype wire
